/* rtl/elevator_request_queue_unit_defines.svh */
// Assertion macros shared by the request queue checker
`ifndef ELEVATOR_REQUEST_QUEUE_UNIT_DEFINES_SVH
`define ELEVATOR_REQUEST_QUEUE_UNIT_DEFINES_SVH

// Plain check, sampled on clk, ignored while rst is high
`define ELEQ_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("elevator queue check failed");

// Implication check, same clocking
`define ELEQ_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("elevator queue implication failed");

`endif

/* rtl/eleq_pkg.sv */
// Types and codes shared by the elevator request queue modules
package eleq_pkg;

  localparam int ACT_BITS = 3;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_INSERT = 3'd0,
    ACT_PAIR   = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_TAKE   = 3'd3,
    ACT_MARK   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_ZERO, IDX_ONE, IDX_INC, IDX_DEC, IDX_USED
  } idx_op_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_IDX, RD_IDX_M1, RD_IDX_P1, RD_ZERO
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_SHIFT_UP, WR_SHIFT_DN, WR_NEW, WR_MARK
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    set_ins;
    logic    ins_second;
    idx_op_t idx_op;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    pos_idx;
    logic    pos_used;
    logic    prev_upd;
    logic    used_inc;
    logic    used_dec;
    logic    set_drop;
    logic    set_found;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [ACT_BITS-1:0] act;
    logic second;
    logic idx_lt_used;
    logic idx_gt_pos;
    logic idx_p1_lt_used;
    logic used_zero;
    logic full;
    logic dup;
    logic hit;
    logic shown;
    logic out_free;
  } sts_t;

endpackage

/* rtl/eleq_if.sv */
// Request and response channel interfaces
interface eleq_req_if #(parameter int FLOOR_BITS = 7) ();
  logic                         valid;
  logic                         ready;
  logic [eleq_pkg::ACT_BITS-1:0] action;
  logic signed [FLOOR_BITS-1:0] first_floor;
  logic signed [FLOOR_BITS-1:0] second_floor;
  logic                         stop_dir;
  modport source (output valid, action, first_floor, second_floor, stop_dir, input ready);
  modport sink (input valid, action, first_floor, second_floor, stop_dir, output ready);
endinterface

interface eleq_rsp_if #(parameter int FLOOR_BITS = 7, parameter int CNT_BITS = 6) ();
  logic                         valid;
  logic                         ready;
  logic signed [FLOOR_BITS-1:0] floor_out;
  logic                         floor_valid;
  logic signed [FLOOR_BITS-1:0] head_floor;
  logic                         is_empty;
  logic [CNT_BITS-1:0]          stop_count;
  logic                         dropped;
  modport source (output valid, floor_out, floor_valid, head_floor, is_empty, stop_count,
                  dropped, input ready);
  modport sink (input valid, floor_out, floor_valid, head_floor, is_empty, stop_count,
                dropped, output ready);
endinterface

/* rtl/eleq_ram.sv */
// Generic single write, single read RAM with registered read data
module eleq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* rtl/eleq_ctrl.sv */
// Sequencer for the request queue: walks, shifts and marks list entries
module eleq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  eleq_pkg::sts_t   sts,
  output eleq_pkg::cmd_t   cmd
);
  typedef enum logic [19:0] {
    S_IDLE       = 20'h00001,
    S_DISP       = 20'h00002,
    S_INS_START  = 20'h00004,
    S_INS_RD     = 20'h00008,
    S_INS_CHK    = 20'h00010,
    S_INS_PLACE  = 20'h00020,
    S_SH_RD      = 20'h00040,
    S_SH_WR      = 20'h00080,
    S_INS_WR     = 20'h00100,
    S_INS_DONE   = 20'h00200,
    S_REM_RD     = 20'h00400,
    S_REM_WR     = 20'h00800,
    S_TN_RD      = 20'h01000,
    S_TN_CHK     = 20'h02000,
    S_MP_RD      = 20'h04000,
    S_MP_CHK     = 20'h08000,
    S_MP_MARK_RD = 20'h10000,
    S_MP_MARK    = 20'h20000,
    S_HEAD_RD    = 20'h40000,
    S_HEAD_CAP   = 20'h80000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.idx_op = eleq_pkg::IDX_HOLD;
    cmd.rd_sel = eleq_pkg::RD_NONE;
    cmd.wr_sel = eleq_pkg::WR_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.act)
          eleq_pkg::ACT_INSERT, eleq_pkg::ACT_PAIR: begin
            cmd.set_ins = 1'b1;
            state_next  = S_INS_START;
          end
          eleq_pkg::ACT_REMOVE: begin
            if (sts.used_zero) begin
              state_next = S_HEAD_RD;
            end else begin
              cmd.idx_op = eleq_pkg::IDX_ONE;
              state_next = S_REM_RD;
            end
          end
          eleq_pkg::ACT_TAKE: begin
            cmd.idx_op = eleq_pkg::IDX_ZERO;
            state_next = S_TN_RD;
          end
          eleq_pkg::ACT_MARK: begin
            cmd.idx_op = eleq_pkg::IDX_ZERO;
            state_next = sts.used_zero ? S_HEAD_RD : S_MP_RD;
          end
          default: state_next = S_HEAD_RD;
        endcase
      end
      S_INS_START: begin
        cmd.idx_op   = eleq_pkg::IDX_ZERO;
        cmd.pos_used = 1'b1;
        state_next   = S_INS_RD;
      end
      S_INS_RD: begin
        if (sts.idx_lt_used) begin
          cmd.rd_sel = eleq_pkg::RD_IDX;
          state_next = S_INS_CHK;
        end else begin
          state_next = S_INS_PLACE;
        end
      end
      S_INS_CHK: begin
        if (sts.dup) begin
          state_next = S_INS_DONE;
        end else if (sts.hit) begin
          cmd.pos_idx = 1'b1;
          state_next  = S_INS_PLACE;
        end else begin
          cmd.prev_upd = 1'b1;
          cmd.idx_op   = eleq_pkg::IDX_INC;
          state_next   = S_INS_RD;
        end
      end
      S_INS_PLACE: begin
        if (sts.full) begin
          cmd.set_drop = 1'b1;
          state_next   = S_INS_DONE;
        end else begin
          cmd.idx_op = eleq_pkg::IDX_USED;
          state_next = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (sts.idx_gt_pos) begin
          cmd.rd_sel = eleq_pkg::RD_IDX_M1;
          state_next = S_SH_WR;
        end else begin
          state_next = S_INS_WR;
        end
      end
      S_SH_WR: begin
        cmd.wr_sel = eleq_pkg::WR_SHIFT_UP;
        cmd.idx_op = eleq_pkg::IDX_DEC;
        state_next = S_SH_RD;
      end
      S_INS_WR: begin
        cmd.wr_sel   = eleq_pkg::WR_NEW;
        cmd.used_inc = 1'b1;
        state_next   = S_INS_DONE;
      end
      S_INS_DONE: begin
        if (sts.act == eleq_pkg::ACT_PAIR && !sts.second) begin
          cmd.set_ins    = 1'b1;
          cmd.ins_second = 1'b1;
          state_next     = S_INS_START;
        end else begin
          state_next = S_HEAD_RD;
        end
      end
      S_REM_RD: begin
        if (sts.idx_lt_used) begin
          cmd.rd_sel = eleq_pkg::RD_IDX;
          state_next = S_REM_WR;
        end else begin
          cmd.used_dec = 1'b1;
          state_next   = S_HEAD_RD;
        end
      end
      S_REM_WR: begin
        cmd.wr_sel = eleq_pkg::WR_SHIFT_DN;
        cmd.idx_op = eleq_pkg::IDX_INC;
        state_next = S_REM_RD;
      end
      S_TN_RD: begin
        if (sts.idx_lt_used) begin
          cmd.rd_sel = eleq_pkg::RD_IDX;
          state_next = S_TN_CHK;
        end else begin
          state_next = S_HEAD_RD;
        end
      end
      S_TN_CHK: begin
        if (!sts.shown) begin
          cmd.wr_sel    = eleq_pkg::WR_MARK;
          cmd.set_found = 1'b1;
          state_next    = S_HEAD_RD;
        end else begin
          cmd.idx_op = eleq_pkg::IDX_INC;
          state_next = S_TN_RD;
        end
      end
      S_MP_RD: begin
        if (sts.idx_p1_lt_used) begin
          cmd.rd_sel = eleq_pkg::RD_IDX_P1;
          state_next = S_MP_CHK;
        end else begin
          state_next = S_MP_MARK_RD;
        end
      end
      S_MP_CHK: begin
        if (sts.shown) begin
          cmd.idx_op = eleq_pkg::IDX_INC;
          state_next = S_MP_RD;
        end else begin
          state_next = S_MP_MARK_RD;
        end
      end
      S_MP_MARK_RD: begin
        cmd.rd_sel = eleq_pkg::RD_IDX;
        state_next = S_MP_MARK;
      end
      S_MP_MARK: begin
        cmd.wr_sel    = eleq_pkg::WR_MARK;
        cmd.set_found = 1'b1;
        state_next    = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        cmd.rd_sel = eleq_pkg::RD_ZERO;
        state_next = S_HEAD_CAP;
      end
      S_HEAD_CAP: begin
        // hold here until the previous word has left the output register
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* rtl/eleq_dp.sv */
// Datapath for the request queue: list memory, index, count and result register
module eleq_dp #(
  parameter int MAX_STOPS  = 32,
  parameter int FLOOR_BITS = 7,
  localparam int IW = $clog2(MAX_STOPS + 1),
  localparam int AW = $clog2(MAX_STOPS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  eleq_pkg::cmd_t                cmd,
  output eleq_pkg::sts_t                sts,
  input  logic [eleq_pkg::ACT_BITS-1:0] in_action,
  input  logic signed [FLOOR_BITS-1:0]  in_first,
  input  logic signed [FLOOR_BITS-1:0]  in_second,
  input  logic                          in_dir,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [FLOOR_BITS-1:0]  floor_out,
  output logic                          floor_valid,
  output logic signed [FLOOR_BITS-1:0]  head_floor,
  output logic                          is_empty,
  output logic [IW-1:0]                 stop_count,
  output logic                          dropped
);
  localparam int EW = FLOOR_BITS + 2;

  logic [eleq_pkg::ACT_BITS-1:0] act;
  logic signed [FLOOR_BITS-1:0]  f1, f2, cur_floor, fout;
  logic                          dir_in, cur_dir, second, prev_dir, drop, found;
  logic [IW-1:0]                 idx, pos, used, idx_m1, idx_p1;

  logic                          we, re;
  logic [AW-1:0]                 waddr, raddr;
  logic [EW-1:0]                 wdata, rdata;
  logic signed [FLOOR_BITS-1:0]  rd_floor;
  logic                          rd_dir, rd_shown;

  assign rd_floor = rdata[EW-1:2];
  assign rd_dir   = rdata[1];
  assign rd_shown = rdata[0];
  assign idx_m1   = idx - IW'(1);
  assign idx_p1   = idx + IW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= in_action;
      f1     <= in_first;
      f2     <= in_second;
      dir_in <= in_dir;
      drop   <= 1'b0;
      found  <= 1'b0;
      fout   <= '0;
    end
    if (cmd.set_ins) begin
      second    <= cmd.ins_second;
      cur_floor <= cmd.ins_second ? f2 : f1;
      // a pair runs down when source lies above destination
      cur_dir   <= (act == eleq_pkg::ACT_PAIR) ? (f1 > f2) : dir_in;
    end
    case (cmd.idx_op)
      eleq_pkg::IDX_ZERO: idx <= '0;
      eleq_pkg::IDX_ONE:  idx <= IW'(1);
      eleq_pkg::IDX_INC:  idx <= idx_p1;
      eleq_pkg::IDX_DEC:  idx <= idx_m1;
      eleq_pkg::IDX_USED: idx <= used;
      default:            idx <= idx;
    endcase
    if (cmd.pos_used) begin
      pos <= used;
    end else if (cmd.pos_idx) begin
      pos <= idx;
    end
    if (cmd.prev_upd) begin
      prev_dir <= rd_dir;
    end
    if (cmd.set_drop) begin
      drop <= 1'b1;
    end
    if (cmd.set_found) begin
      found <= 1'b1;
      fout  <= rd_floor;
    end
    if (cmd.out_load) begin
      floor_out   <= found ? fout : '0;
      floor_valid <= found;
      head_floor  <= (used == '0) ? '0 : rd_floor;
      is_empty    <= (used == '0);
      stop_count  <= used;
      dropped     <= drop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.used_inc) begin
        used <= used + IW'(1);
      end else if (cmd.used_dec) begin
        used <= used - IW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    re    = 1'b1;
    raddr = '0;
    case (cmd.rd_sel)
      eleq_pkg::RD_IDX:    raddr = idx[AW-1:0];
      eleq_pkg::RD_IDX_M1: raddr = idx_m1[AW-1:0];
      eleq_pkg::RD_IDX_P1: raddr = idx_p1[AW-1:0];
      eleq_pkg::RD_ZERO:   raddr = '0;
      default:             re    = 1'b0;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = idx[AW-1:0];
    wdata = rdata;
    case (cmd.wr_sel)
      eleq_pkg::WR_SHIFT_UP: waddr = idx[AW-1:0];
      eleq_pkg::WR_SHIFT_DN: waddr = idx_m1[AW-1:0];
      eleq_pkg::WR_NEW: begin
        waddr = pos[AW-1:0];
        wdata = {cur_floor, cur_dir, 1'b0};
      end
      eleq_pkg::WR_MARK: wdata = {rd_floor, rd_dir, 1'b1};
      default:           we = 1'b0;
    endcase
  end

  eleq_ram #(.WIDTH(EW), .DEPTH(MAX_STOPS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sts                = '0;
    sts.act            = act;
    sts.second         = second;
    sts.idx_lt_used    = (idx < used);
    sts.idx_gt_pos     = (idx > pos);
    sts.idx_p1_lt_used = ({1'b0, idx} + (IW+1)'(1)) < {1'b0, used};
    sts.used_zero      = (used == '0);
    sts.full           = (used >= IW'(MAX_STOPS));
    sts.dup            = (rd_dir == cur_dir) && (rd_floor == cur_floor) && !rd_shown;
    sts.hit            = (!cur_dir && !rd_dir && (cur_floor < rd_floor)) ||
                         (cur_dir && rd_dir && (cur_floor > rd_floor)) ||
                         ((rd_dir != cur_dir) && (idx != '0) && (prev_dir == cur_dir));
    sts.shown          = rd_shown;
    sts.out_free       = !out_valid || out_ready;
  end
endmodule

/* rtl/elevator_request_queue_unit.sv */
// Elevator request queue: top level joining sequencer and datapath
//
// channel  dir  word
// req      in   action, first_floor, second_floor, stop_dir
// rsp      out  floor_out, floor_valid, head_floor, is_empty, stop_count, dropped
//
// One request at a time; each list access goes through the single memory read port.
// Insert walks the list and shifts later entries up, twice over for a pair.
// Remove shifts the entries behind the head down; take-next and mark-previous walk the list.
// rst clears the count and output valid; list contents are not cleared.
// A stalled rsp holds the word and blocks only the next finished result.
module elevator_request_queue_unit #(
  parameter int MAX_STOPS  = 32,
  parameter int FLOOR_BITS = 7
) (
  input logic       clk,
  input logic       rst,
  eleq_req_if.sink  req,
  eleq_rsp_if.source rsp
);
  eleq_pkg::cmd_t cmd;
  eleq_pkg::sts_t sts;

  eleq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  eleq_dp #(.MAX_STOPS(MAX_STOPS), .FLOOR_BITS(FLOOR_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_action   (req.action),
    .in_first    (req.first_floor),
    .in_second   (req.second_floor),
    .in_dir      (req.stop_dir),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .floor_out   (rsp.floor_out),
    .floor_valid (rsp.floor_valid),
    .head_floor  (rsp.head_floor),
    .is_empty    (rsp.is_empty),
    .stop_count  (rsp.stop_count),
    .dropped     (rsp.dropped)
  );
endmodule

/* rtl/eleq_check.sv */
// Port-level checks for the request queue, bound to the top level
`include "elevator_request_queue_unit_defines.svh"

module eleq_check #(
  parameter int MAX_STOPS  = 32,
  parameter int FLOOR_BITS = 7,
  localparam int IW = $clog2(MAX_STOPS + 1)
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [FLOOR_BITS-1:0] floor_out,
  input logic                  floor_valid,
  input logic [FLOOR_BITS-1:0] head_floor,
  input logic                  is_empty,
  input logic [IW-1:0]         stop_count
);
  `ELEQ_IMPLY(a_empty_count, rsp_valid, is_empty == (stop_count == '0))
  `ELEQ_IMPLY(a_empty_head, rsp_valid && is_empty, head_floor == '0)
  `ELEQ_IMPLY(a_no_floor_zero, rsp_valid && !floor_valid, floor_out == '0)
  `ELEQ_CHECK(a_count_max, !rsp_valid || (stop_count <= IW'(MAX_STOPS)))
  `ELEQ_IMPLY(a_stall_hold, rsp_valid && !rsp_ready, ##1 ($stable(stop_count) && rsp_valid))
endmodule

bind elevator_request_queue_unit eleq_check #(
  .MAX_STOPS(MAX_STOPS), .FLOOR_BITS(FLOOR_BITS)
) u_eleq_check (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .floor_out   (rsp.floor_out),
  .floor_valid (rsp.floor_valid),
  .head_floor  (rsp.head_floor),
  .is_empty    (rsp.is_empty),
  .stop_count  (rsp.stop_count)
);
